[hw/rtl/tksi_pkg.sv]
`default_nettype none

package tksi_pkg;

  localparam int unsigned SCORE_W  = 16;
  localparam int unsigned TAG_W    = 16;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned RANK_W   = 4;
  localparam int unsigned RD_IDX_W = 4;

  // Operation codes carried in the mode field
  localparam logic [MODE_W-1:0] MODE_TEST   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [SCORE_W-1:0]  new_score;
    logic [TAG_W-1:0]    player_tag;
    logic [RD_IDX_W-1:0] read_rank;
  } in_item_t;

  typedef struct packed {
    logic                qualifies;
    logic [RANK_W-1:0]   placed_rank;
    logic [SCORE_W-1:0]  entry_score;
    logic [TAG_W-1:0]    entry_tag;
  } out_item_t;

  // Per-cell update control
  typedef struct packed {
    logic load_new;   // take the offered pair
    logic load_prev;  // take the neighbor above
  } cell_ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/top_k_sorted_insert_top.sv]
`default_nettype none

// Top-K score table: ENTRIES (score, tag) pairs kept in descending score order
// in a chain of cells, all zero after reset. Each input item returns exactly
// one result item. Mode 0 tests whether new_score is strictly above the
// lowest entry and reports the rank it would take; mode 1 does the same and,
// if it qualifies, drops the lowest entry and places the pair below every
// entry of equal or higher score; mode 2 returns the entry at read_rank
// (zero beyond the table). When a score does not qualify, or for a read or
// the unused mode 3, placed_rank is ENTRIES (low four bits). Throughput is
// one item per clock while the output is not stalled: every cell compares
// its score with the offered one in parallel, and on an insert each cell
// below the landing point takes its upper neighbor's pair in the same edge.
// Results are held in the output register; the input is ready whenever that
// register is empty or is being taken in the same cycle.
module top_k_sorted_insert_top #(
  parameter int unsigned ENTRIES = 10  // 2 to 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire tksi_pkg::in_item_t  in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output tksi_pkg::out_item_t      out_item_o
);
  import tksi_pkg::*;

  // Wide enough to hold ENTRIES itself (the "not placed" code)
  localparam int unsigned IDX_W = $clog2(ENTRIES + 1);
  // Common width for comparing the 4-bit read rank with a cell index
  localparam int unsigned CMP_W = (IDX_W > RD_IDX_W) ? IDX_W : RD_IDX_W;

  // ---------------------------------------------------------------------
  // Cell chain
  // ---------------------------------------------------------------------
  logic [ENTRIES-1:0][SCORE_W-1:0] cell_score;
  logic [ENTRIES-1:0][TAG_W-1:0]   cell_tag;
  logic [ENTRIES-1:0]              cell_lt;     // cell score < offered score
  logic [ENTRIES-1:0]              cell_first;  // landing cell (one-hot or none)
  logic [ENTRIES-1:0]              cell_hit;    // read rank selects this cell

  logic accept;
  logic qualify;
  logic do_insert;

  assign accept    = in_valid_i && in_ready_o;
  // Table is sorted, so cell_lt is a suffix of ones; the last cell decides.
  assign qualify   = cell_lt[ENTRIES-1];
  assign do_insert = accept && (in_item_i.mode == MODE_INSERT) && qualify;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic [SCORE_W-1:0] prev_score;
    logic [TAG_W-1:0]   prev_tag;
    logic               prev_lt;
    cell_ctrl_t         ctrl;

    if (i == 0) begin : g_head
      assign prev_score = '0;
      assign prev_tag   = '0;
      assign prev_lt    = 1'b0;
    end else begin : g_body
      assign prev_score = cell_score[i-1];
      assign prev_tag   = cell_tag[i-1];
      assign prev_lt    = cell_lt[i-1];
    end

    assign cell_first[i]  = cell_lt[i] && !prev_lt;
    assign ctrl.load_new  = do_insert && cell_first[i];
    assign ctrl.load_prev = do_insert && cell_lt[i] && prev_lt;
    assign cell_hit[i]    = (CMP_W'(in_item_i.read_rank) == CMP_W'(i));

    tksi_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_score_i  (in_item_i.new_score),
      .new_tag_i    (in_item_i.player_tag),
      .prev_score_i (prev_score),
      .prev_tag_i   (prev_tag),
      .score_o      (cell_score[i]),
      .tag_o        (cell_tag[i]),
      .lt_o         (cell_lt[i])
    );
  end

  // ---------------------------------------------------------------------
  // Result formation
  // ---------------------------------------------------------------------
  logic [IDX_W-1:0]   land_rank;
  logic [SCORE_W-1:0] rd_score;
  logic [TAG_W-1:0]   rd_tag;
  out_item_t          res;

  // Encode the landing cell; also an AND-OR select for the read port
  always_comb begin
    land_rank = '0;
    rd_score  = '0;
    rd_tag    = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (cell_first[i]) begin
        land_rank = land_rank | IDX_W'(i);
      end
      if (cell_hit[i]) begin
        rd_score = rd_score | cell_score[i];
        rd_tag   = rd_tag | cell_tag[i];
      end
    end
  end

  always_comb begin
    res.qualifies   = 1'b0;
    res.placed_rank = RANK_W'(IDX_W'(ENTRIES));
    res.entry_score = '0;
    res.entry_tag   = '0;
    unique case (in_item_i.mode)
      MODE_TEST, MODE_INSERT: begin
        if (qualify) begin
          res.qualifies   = 1'b1;
          res.placed_rank = RANK_W'(land_rank);
        end
      end
      MODE_READ: begin
        res.entry_score = rd_score;
        res.entry_tag   = rd_tag;
      end
      default: begin
        // unused code: defaults stand
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  assign in_ready_o = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (accept) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  logic [ENTRIES-2:0] sorted_pair;

  always_comb begin
    for (int i = 0; i < ENTRIES - 1; i++) begin
      sorted_pair[i] = (cell_score[i] >= cell_score[i+1]);
    end
  end

  a_table_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    &sorted_pair)
    else $error("score table lost descending order");

  a_single_landing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cell_first))
    else $error("more than one landing cell");

  a_floor_rises: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_insert |=> cell_score[ENTRIES-1] >= $past(cell_score[ENTRIES-1]))
    else $error("lowest score dropped on insert");

  a_table_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !do_insert |=> $stable(cell_score) && $stable(cell_tag))
    else $error("table changed without a qualifying insert");

endmodule

`default_nettype wire

[hw/rtl/tksi_cell.sv]
`default_nettype none

module tksi_cell (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire tksi_pkg::cell_ctrl_t         ctrl_i,
  input  wire logic [tksi_pkg::SCORE_W-1:0] new_score_i,
  input  wire logic [tksi_pkg::TAG_W-1:0]   new_tag_i,
  input  wire logic [tksi_pkg::SCORE_W-1:0] prev_score_i,
  input  wire logic [tksi_pkg::TAG_W-1:0]   prev_tag_i,
  output logic      [tksi_pkg::SCORE_W-1:0] score_o,
  output logic      [tksi_pkg::TAG_W-1:0]   tag_o,
  output logic                              lt_o
);
  import tksi_pkg::*;

  logic [SCORE_W-1:0] score_q, score_d;
  logic [TAG_W-1:0]   tag_q, tag_d;

  always_comb begin
    score_d = score_q;
    tag_d   = tag_q;
    if (ctrl_i.load_new) begin
      score_d = new_score_i;
      tag_d   = new_tag_i;
    end else if (ctrl_i.load_prev) begin
      score_d = prev_score_i;
      tag_d   = prev_tag_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      score_q <= '0;
      tag_q   <= '0;
    end else begin
      score_q <= score_d;
      tag_q   <= tag_d;
    end
  end

  // Offered score beats this entry
  assign lt_o    = (score_q < new_score_i);
  assign score_o = score_q;
  assign tag_o   = tag_q;

endmodule

`default_nettype wire
